FILE: sv/tss_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the divider step for the triangle scanline span block
// no dependencies
package tss_pkg;

    localparam int COORD_W     = 10;
    localparam int SCREEN_SIZE = 1024;
    localparam int NUM_W       = 2 * COORD_W;
    localparam int DEN_W       = COORD_W + 1;
    localparam int Q_W         = COORD_W;
    localparam int DIV_BITS    = 2;
    localparam int DIV_STAGES  = Q_W / DIV_BITS;
    localparam int SUM_W       = COORD_W + 2;
    localparam int IN_W        = 72;
    localparam int OUT_W       = 24;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_vtx;

    // partial remainder, pending dividend bits, quotient so far, divisor
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   low;
        logic [Q_W-1:0]   quo;
        logic [DEN_W-1:0] den;
    } t_div_st;

    // one restoring division step: one quotient bit
    function automatic t_div_st div_step(input t_div_st s);
        t_div_st      o;
        logic [DEN_W:0] sh;
        logic         qb;
        o  = s;
        sh = {o.rem, o.low[Q_W-1]};
        o.low = {o.low[Q_W-2:0], 1'b0};
        qb = 1'b0;
        if (sh >= {1'b0, o.den}) begin
            sh = sh - {1'b0, o.den};
            qb = 1'b1;
        end
        o.rem = sh[DEN_W-1:0];
        o.quo = {o.quo[Q_W-2:0], qb};
        return o;
    endfunction

endpackage

FILE: sv/tss_sort.sv
`timescale 1ns / 1ps
// three compare-and-swap network ordering vertices by y, registered output
// depends on tss_pkg
module tss_sort (
    input  logic          i_clk,
    input  logic          i_en,
    input  tss_pkg::t_vtx i_a,
    input  tss_pkg::t_vtx i_b,
    input  tss_pkg::t_vtx i_c,
    output tss_pkg::t_vtx o_lo,
    output tss_pkg::t_vtx o_mid,
    output tss_pkg::t_vtx o_hi
);
    import tss_pkg::*;

    t_vtx n_lo, n_mid, n_hi, r_lo, r_mid, r_hi;
    t_vtx t;

    always_comb begin
        n_lo  = i_a;
        n_mid = i_b;
        n_hi  = i_c;
        // swap only on strictly larger y; equal-y vertices do not always keep input order
        if (n_lo.y > n_hi.y) begin
            t = n_lo; n_lo = n_hi; n_hi = t;
        end
        if (n_lo.y > n_mid.y) begin
            t = n_lo; n_lo = n_mid; n_mid = t;
        end
        if (n_mid.y > n_hi.y) begin
            t = n_mid; n_mid = n_hi; n_hi = t;
        end else begin
            t = n_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo  <= n_lo;
            r_mid <= n_mid;
            r_hi  <= n_hi;
        end
    end

    assign o_lo  = r_lo;
    assign o_mid = r_mid;
    assign o_hi  = r_hi;

endmodule

FILE: sv/tss_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, DIV_BITS quotient bits per stage
// depends on tss_pkg
module tss_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [tss_pkg::NUM_W-1:0] i_num,
    input  logic [tss_pkg::DEN_W-1:0] i_den,
    output logic [tss_pkg::Q_W-1:0]   o_quo,
    output logic                      o_rem_nz
);
    import tss_pkg::*;

    t_div_st r_st [DIV_STAGES];
    t_div_st n_st [DIV_STAGES];
    t_div_st w_in [DIV_STAGES];

    // quotient fits Q_W bits, so the upper dividend half starts as remainder
    always_comb begin
        w_in[0].rem = {1'b0, i_num[NUM_W-1:Q_W]};
        w_in[0].low = i_num[Q_W-1:0];
        w_in[0].quo = '0;
        w_in[0].den = i_den;
    end

    for (genvar g = 1; g < DIV_STAGES; g++) begin : g_link
        assign w_in[g] = r_st[g-1];
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        always_comb begin
            n_st[g] = w_in[g];
            for (int k = 0; k < DIV_BITS; k++) begin
                n_st[g] = div_step(n_st[g]);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g] <= n_st[g];
            end
        end
    end

    assign o_quo    = r_st[DIV_STAGES-1].quo;
    assign o_rem_nz = |r_st[DIV_STAGES-1].rem;

endmodule

FILE: sv/triangle_scanline_span_top.sv
`timescale 1ns / 1ps
// top level of the triangle scanline span block: sort, edge setup, dividers, span
// depends on tss_pkg, tss_sort, tss_div
//
// usage
//   input stream: one transfer carries three vertices and one row number
//   output stream: one transfer per input transfer, in order; tuser is the row
//   hit flag, tdata the inclusive left and right span columns (0 when not hit)
//   pipeline: eight register stages from input to output
//   throughput: one item per cycle while the output is taken, set by the fully pipelined dividers
//   stages: vertex sort, edge setup with one multiplier per edge,
//   five divider stages of two quotient bits each, then floor fix-up,
//   min/max and clamp into the output register
//   reset: synchronous active low, clears all valid bits; payload is not reset
//   stall: when the output is held and not taken the whole pipe freezes and
//   s_tready drops; bubbles inside the pipe are not squeezed out, the pipe
//   only runs on while the output register is empty or being taken
module triangle_scanline_span_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y, row, zero pad
    input  logic [tss_pkg::IN_W-1:0]    i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // span_left, span_right, zero pad
    output logic [tss_pkg::OUT_W-1:0]   o_m_tdata,
    // row_hit
    output logic                        o_m_tuser
);
    import tss_pkg::*;

    localparam int CW = COORD_W;

    typedef struct packed {
        logic          hit;
        logic [CW-1:0] a_base;
        logic [CW-1:0] b_base;
        logic          a_neg;
        logic          b_neg;
    } t_side;

    // global advance: pipe moves unless a held output is not taken
    logic w_en;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // ---------------- stage 1: sort
    t_vtx w_a, w_b, w_c, w_lo, w_mid, w_hi;
    logic          r_s_vld;
    logic [CW-1:0] r_s_row;

    assign w_a = '{x: i_s_tdata[CW-1:0],     y: i_s_tdata[2*CW-1:CW]};
    assign w_b = '{x: i_s_tdata[3*CW-1:2*CW], y: i_s_tdata[4*CW-1:3*CW]};
    assign w_c = '{x: i_s_tdata[5*CW-1:4*CW], y: i_s_tdata[6*CW-1:5*CW]};

    tss_sort u_sort (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_a),
        .i_b   (w_b),
        .i_c   (w_c),
        .o_lo  (w_lo),
        .o_mid (w_mid),
        .o_hi  (w_hi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (w_en) begin
            r_s_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_row <= i_s_tdata[7*CW-1:6*CW];
        end
    end

    // ---------------- stage 2: edge setup and numerator products
    logic          n_hit, n_upper;
    logic [CW:0]   n_adx, n_bdx, n_at, n_bt, n_aden, n_bden;
    logic [CW-1:0] n_amag, n_bmag, n_abase;
    logic [2*CW:0] n_anum, n_bnum;

    logic          r_m_vld;
    t_side         r_m_side;
    logic [NUM_W-1:0] r_m_anum, r_m_bnum;
    logic [DEN_W-1:0] r_m_aden, r_m_bden;

    always_comb begin
        n_hit   = (r_s_row >= w_lo.y) && (r_s_row <= w_hi.y);
        n_upper = r_s_row < w_mid.y;
        // short edge: upper half lo->mid, lower half mid->hi
        if (n_upper) begin
            n_abase = w_lo.x;
            n_adx   = {1'b0, w_mid.x} - {1'b0, w_lo.x};
            n_at    = {1'b0, r_s_row} - {1'b0, w_lo.y} + (CW+1)'(1);
            n_aden  = {1'b0, w_mid.y} - {1'b0, w_lo.y};
        end else begin
            n_abase = w_mid.x;
            n_adx   = {1'b0, w_hi.x} - {1'b0, w_mid.x};
            n_at    = {1'b0, r_s_row} - {1'b0, w_mid.y} + (CW+1)'(1);
            n_aden  = {1'b0, w_hi.y} - {1'b0, w_mid.y} + (CW+1)'(1);
        end
        // long edge lo->hi
        n_bdx  = {1'b0, w_hi.x} - {1'b0, w_lo.x};
        n_bt   = {1'b0, r_s_row} - {1'b0, w_lo.y} + (CW+1)'(1);
        n_bden = {1'b0, w_hi.y} - {1'b0, w_lo.y} + (CW+1)'(1);
        n_amag = n_adx[CW] ? CW'(-n_adx) : n_adx[CW-1:0];
        n_bmag = n_bdx[CW] ? CW'(-n_bdx) : n_bdx[CW-1:0];
        n_anum = n_amag * n_at;
        n_bnum = n_bmag * n_bt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_side <= '{hit: n_hit, a_base: n_abase, b_base: w_lo.x,
                          a_neg: n_adx[CW], b_neg: n_bdx[CW]};
            r_m_anum <= n_anum[NUM_W-1:0];
            r_m_bnum <= n_bnum[NUM_W-1:0];
            r_m_aden <= n_aden;
            r_m_bden <= n_bden;
        end
    end

    // ---------------- stages 3..7: dividers with sideband delay line
    logic [Q_W-1:0] w_aquo, w_bquo;
    logic           w_anz, w_bnz;

    tss_div u_div_a (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num    (r_m_anum),
        .i_den    (r_m_aden),
        .o_quo    (w_aquo),
        .o_rem_nz (w_anz)
    );

    tss_div u_div_b (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num    (r_m_bnum),
        .i_den    (r_m_bden),
        .o_quo    (w_bquo),
        .o_rem_nz (w_bnz)
    );

    logic  r_d_vld  [DIV_STAGES];
    t_side r_d_side [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_d_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_d_vld[0] <= r_m_vld;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_d_vld[k] <= r_d_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_side[0] <= r_m_side;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_d_side[k] <= r_d_side[k-1];
            end
        end
    end

    // ---------------- stage 8: floor fix-up, min/max, clamp
    t_side                r_last;
    logic signed [SUM_W-1:0] n_aq, n_bq, n_ax, n_bx, n_lft, n_rgt;
    logic [CW-1:0]        n_left, n_right;
    logic                 r_out_vld, r_out_hit;
    logic [CW-1:0]        r_out_left, r_out_right;

    assign r_last = r_d_side[DIV_STAGES-1];

    function automatic logic [CW-1:0] clamp_col(input logic signed [SUM_W-1:0] v);
        logic [CW-1:0] c;
        if (v < 0) begin
            c = '0;
        end else if (v > SUM_W'(SCREEN_SIZE - 1)) begin
            c = CW'(SCREEN_SIZE - 1);
        end else begin
            c = v[CW-1:0];
        end
        return c;
    endfunction

    always_comb begin
        // negative numerator: floor = -(trunc) - 1 when a remainder is left
        n_aq = r_last.a_neg ? -($signed({2'b00, w_aquo}) + SUM_W'(w_anz))
                            : $signed({2'b00, w_aquo});
        n_bq = r_last.b_neg ? -($signed({2'b00, w_bquo}) + SUM_W'(w_bnz))
                            : $signed({2'b00, w_bquo});
        n_ax = $signed({2'b00, r_last.a_base}) + n_aq;
        n_bx = $signed({2'b00, r_last.b_base}) + n_bq;
        n_lft = (n_ax < n_bx) ? n_ax : n_bx;
        n_rgt = (n_ax < n_bx) ? n_bx : n_ax;
        n_left  = r_last.hit ? clamp_col(n_lft) : '0;
        n_right = r_last.hit ? clamp_col(n_rgt) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_d_vld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_hit   <= r_last.hit;
            r_out_left  <= n_left;
            r_out_right <= n_right;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out_hit;
    assign o_m_tdata  = {(OUT_W - 2*CW)'(0), r_out_right, r_out_left};

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> r_out_left == '0 && r_out_right == '0)
        else $error("missed row with nonzero span");
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_out_left <= r_out_right)
        else $error("span left beyond right");
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while output stalled");
`endif

endmodule
